[hw/rtl/frustum_box_cull_test_defines.svh]
// Assertion macros for the frustum box cull test
`ifndef FRUSTUM_BOX_CULL_TEST_DEFINES_SVH
`define FRUSTUM_BOX_CULL_TEST_DEFINES_SVH

`ifndef SYNTHESIS

`define FBCT_ASSERT_NOW(lbl, clk, rstn, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
        else $error(msg);

`define FBCT_ASSERT_NORST(lbl, clk, pre, post, msg) \
    lbl: assert property (@(posedge clk) (pre) |-> (post)) else $error(msg);

`else

`define FBCT_ASSERT_NOW(lbl, clk, rstn, pre, post, msg)

`define FBCT_ASSERT_NORST(lbl, clk, pre, post, msg)

`endif

`endif

[hw/rtl/fbct_pkg.sv]
`timescale 1ns / 1ps

package fbct_pkg;

    localparam int PlaneCount = 6;
    localparam int RegCount   = 6;

    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 64;

    localparam int FuncW  = 2;
    localparam int CoordW = 16;
    localparam int SizeW  = 12;
    localparam int NormW  = 12;
    localparam int OffW   = 28;
    localparam int VtxW   = 17;
    localparam int ProdW  = NormW + VtxW;
    localparam int DistW  = 32;

    localparam int STdataW = 88;
    localparam int MTdataW = 8;

    localparam logic [FuncW-1:0] FuncPoint  = 2'd0;
    localparam logic [FuncW-1:0] FuncBox    = 2'd1;
    localparam logic [FuncW-1:0] FuncColumn = 2'd2;

    typedef struct packed {
        logic [FuncW-1:0]         func;
        logic signed [CoordW-1:0] pos_x;
        logic signed [CoordW-1:0] pos_y;
        logic signed [CoordW-1:0] pos_z;
        logic [SizeW-1:0]         size_x;
        logic signed [CoordW-1:0] size_y;
        logic [SizeW-1:0]         size_z;
        logic                     visible;
    } item_t;

endpackage

[hw/rtl/fbct_cell.sv]
`timescale 1ns / 1ps

module fbct_cell (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          plane_we,
    input  logic [fbct_pkg::CfgDataW-1:0] plane_wdata,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  fbct_pkg::item_t               in_item,
    output logic                          out_valid,
    input  logic                          out_ready,
    output fbct_pkg::item_t               out_item
);

    logic [fbct_pkg::CfgDataW-1:0] plane_reg;

    logic                 v1_reg;
    fbct_pkg::item_t      item1_reg;
    logic signed [fbct_pkg::ProdW-1:0] prod_x_reg;
    logic signed [fbct_pkg::ProdW-1:0] prod_y_reg;
    logic signed [fbct_pkg::ProdW-1:0] prod_z_reg;

    logic                 v2_reg;
    fbct_pkg::item_t      item2_reg;

    logic ready1;
    logic ready2;

    logic signed [fbct_pkg::NormW-1:0] nx;
    logic signed [fbct_pkg::NormW-1:0] ny;
    logic signed [fbct_pkg::NormW-1:0] nz;
    logic signed [fbct_pkg::OffW-1:0]  off;
    logic                              box;
    logic                              column;
    logic signed [fbct_pkg::VtxW-1:0]  vx;
    logic signed [fbct_pkg::VtxW-1:0]  vy;
    logic signed [fbct_pkg::VtxW-1:0]  vz;
    logic signed [fbct_pkg::DistW-1:0] dist_sum;
    fbct_pkg::item_t                   item2_next;

    assign nx  = plane_reg[11:0];
    assign ny  = plane_reg[23:12];
    assign nz  = plane_reg[35:24];
    assign off = plane_reg[63:36];

    assign ready2   = !v2_reg || out_ready;
    assign ready1   = !v1_reg || ready2;
    assign in_ready = ready1;

    always_comb begin
        box    = (in_item.func == fbct_pkg::FuncBox) || (in_item.func == fbct_pkg::FuncColumn);
        column = (in_item.func == fbct_pkg::FuncColumn);
        vx = {in_item.pos_x[15], in_item.pos_x};
        vy = {in_item.pos_y[15], in_item.pos_y};
        vz = {in_item.pos_z[15], in_item.pos_z};
        if (box && (nx > 0)) begin
            vx = {in_item.pos_x[15], in_item.pos_x} + {5'b0, in_item.size_x};
        end
        if (box && (ny > 0)) begin
            if (column) begin
                vy = {in_item.size_y[15], in_item.size_y};
            end else begin
                vy = {in_item.pos_y[15], in_item.pos_y} + {in_item.size_y[15], in_item.size_y};
            end
        end
        if (box && (nz > 0)) begin
            vz = {in_item.pos_z[15], in_item.pos_z} + {5'b0, in_item.size_z};
        end
    end

    always_comb begin
        dist_sum = {{(fbct_pkg::DistW-fbct_pkg::ProdW){prod_x_reg[fbct_pkg::ProdW-1]}}, prod_x_reg}
                 + {{(fbct_pkg::DistW-fbct_pkg::ProdW){prod_y_reg[fbct_pkg::ProdW-1]}}, prod_y_reg}
                 + {{(fbct_pkg::DistW-fbct_pkg::ProdW){prod_z_reg[fbct_pkg::ProdW-1]}}, prod_z_reg}
                 + {{(fbct_pkg::DistW-fbct_pkg::OffW){off[fbct_pkg::OffW-1]}}, off};
        item2_next         = item1_reg;
        item2_next.visible = item1_reg.visible && !dist_sum[fbct_pkg::DistW-1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            plane_reg <= '0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
        end else begin
            if (plane_we) begin
                plane_reg <= plane_wdata;
            end
            if (ready1) begin
                v1_reg <= in_valid;
            end
            if (ready2) begin
                v2_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ready1 && in_valid) begin
            item1_reg  <= in_item;
            prod_x_reg <= nx * vx;
            prod_y_reg <= ny * vy;
            prod_z_reg <= nz * vz;
        end
        if (ready2 && v1_reg) begin
            item2_reg <= item2_next;
        end
    end

    assign out_valid = v2_reg;
    assign out_item  = item2_reg;

endmodule

[hw/rtl/frustum_box_cull_test.sv]
`timescale 1ns / 1ps
// An accepted item passes the multiply and sum registers of every plane cell in turn before m_tvalid.
// Throughput: one item per cycle while m_tready is high; each plane cell has a multiply stage and a sum stage.
// Every stage takes a new item as soon as its successor moves or it is empty.
// Reset (aresetn low, synchronous) empties the pipeline and clears all planes to zero.
`include "frustum_box_cull_test_defines.svh"

module frustum_box_cull_test #(
    parameter int PLANE_COUNT = fbct_pkg::PlaneCount
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [fbct_pkg::CfgIdxW-1:0]  cfg_index,
    input  logic [fbct_pkg::CfgDataW-1:0] cfg_wdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // pos_x, pos_y, pos_z, size_x, size_y, size_z
    input  logic [fbct_pkg::STdataW-1:0]  s_tdata,
    // func
    input  logic [fbct_pkg::FuncW-1:0]    s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // visible, zero pad
    output logic [fbct_pkg::MTdataW-1:0]  m_tdata
);

    logic            chain_valid [0:PLANE_COUNT];
    logic            chain_ready [0:PLANE_COUNT];
    fbct_pkg::item_t chain_item  [0:PLANE_COUNT];

    always_comb begin
        chain_item[0].func    = s_tuser;
        chain_item[0].pos_x   = s_tdata[15:0];
        chain_item[0].pos_y   = s_tdata[31:16];
        chain_item[0].pos_z   = s_tdata[47:32];
        chain_item[0].size_x  = s_tdata[59:48];
        chain_item[0].size_y  = s_tdata[75:60];
        chain_item[0].size_z  = s_tdata[87:76];
        chain_item[0].visible = 1'b1;
    end

    assign chain_valid[0] = s_tvalid;
    assign s_tready       = chain_ready[0];

    for (genvar i = 0; i < PLANE_COUNT; i++) begin : g_cell
        logic plane_we;

        assign plane_we = cfg_wr_en && (i < fbct_pkg::RegCount)
                          && (cfg_index == fbct_pkg::CfgIdxW'(i));

        fbct_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .plane_we    (plane_we),
            .plane_wdata (cfg_wdata),
            .in_valid    (chain_valid[i]),
            .in_ready    (chain_ready[i]),
            .in_item     (chain_item[i]),
            .out_valid   (chain_valid[i+1]),
            .out_ready   (chain_ready[i+1]),
            .out_item    (chain_item[i+1])
        );
    end

    assign chain_ready[PLANE_COUNT] = m_tready;
    assign m_tvalid = chain_valid[PLANE_COUNT];
    assign m_tdata  = {{(fbct_pkg::MTdataW-1){1'b0}}, chain_item[PLANE_COUNT].visible};

    `FBCT_ASSERT_NOW(a_stall_only_when_full, aclk, aresetn, !s_tready, m_tvalid && !m_tready, "input stalled while output is free")
    `FBCT_ASSERT_NORST(a_reset_empties, aclk, $past(!aresetn), !m_tvalid, "result valid right after reset")

endmodule

[tb/frustum_box_cull_test_tb.sv]
`timescale 1ns / 1ps

module frustum_box_cull_test_tb;

    import fbct_pkg::*;

    localparam int CycleLimit   = 400000;
    localparam int HoldCycles   = 300;
    localparam int DrainCycles  = 30;
    localparam int PhaseItems   = 300;
    localparam int QuietCycles  = 20;
    localparam int FirstFreeIdx = RegCount;

    localparam logic [FuncW-1:0] FuncSpare = 2'd3;

    class cull_scoreboard;
        logic [CfgDataW-1:0] planes [PlaneCount];
        bit                  visible_q [$];
        int                  errors;
        int                  checked;
        int                  seen_visible;

        function new();
            foreach (planes[i]) planes[i] = '0;
            errors       = 0;
            checked      = 0;
            seen_visible = 0;
        endfunction

        function void set_plane(int idx, logic [CfgDataW-1:0] value);
            if (idx < PlaneCount) planes[idx] = value;
        endfunction

        function bit cull_verdict(item_t it);
            longint nx, ny, nz, off, x, y, z, dist_sum;
            bit     box_mode, column_mode, vis;
            box_mode    = (it.func == FuncBox) || (it.func == FuncColumn);
            column_mode = (it.func == FuncColumn);
            vis = 1'b1;
            foreach (planes[i]) begin
                nx  = longint'($signed(planes[i][11:0]));
                ny  = longint'($signed(planes[i][23:12]));
                nz  = longint'($signed(planes[i][35:24]));
                off = longint'($signed(planes[i][63:36]));
                x   = longint'(it.pos_x);
                y   = longint'(it.pos_y);
                z   = longint'(it.pos_z);
                if (box_mode) begin
                    if (nx > 0) x = x + longint'({1'b0, it.size_x});
                    if (ny > 0) y = column_mode ? longint'(it.size_y)
                                                : y + longint'(it.size_y);
                    if (nz > 0) z = z + longint'({1'b0, it.size_z});
                end
                dist_sum = nx * x + ny * y + nz * z + off;
                if (dist_sum < 0) vis = 1'b0;
            end
            return vis;
        endfunction

        function void note_item(item_t it);
            visible_q.push_back(cull_verdict(it));
        endfunction

        function void check_result(logic [MTdataW-1:0] data);
            bit want;
            if (visible_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual visible=%0b",
                         $time, data[0]);
                errors++;
                return;
            end
            want = visible_q.pop_front();
            checked++;
            if (data[0]) seen_visible++;
            if (data[0] !== want) begin
                $display("%0t: visible mismatch, expected %0b, actual %0b",
                         $time, want, data[0]);
                errors++;
            end
        endfunction

        function int pending();
            return visible_q.size();
        endfunction
    endclass

    logic                aclk;
    logic                aresetn;
    logic                cfg_wr_en;
    logic [CfgIdxW-1:0]  cfg_index;
    logic [CfgDataW-1:0] cfg_wdata;
    logic                s_tvalid;
    logic                s_tready;
    logic [STdataW-1:0]  s_tdata;
    logic [FuncW-1:0]    s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    logic [MTdataW-1:0]  m_tdata;

    cull_scoreboard      sb;
    logic [CfgDataW-1:0] plane_set [PlaneCount];
    bit                  no_gaps;
    bit                  hold_req;
    int                  cycle_count;
    int                  settings_used;
    int                  items_sent;

    frustum_box_cull_test dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        aclk = 1'b1;
        #2;
        aclk = 1'b0;
        #2;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CycleLimit) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic logic [CfgDataW-1:0] pack_plane(logic [NormW-1:0] nx,
                                                      logic [NormW-1:0] ny,
                                                      logic [NormW-1:0] nz,
                                                      logic [OffW-1:0] off);
        return {off, nz, ny, nx};
    endfunction

    function automatic logic [CfgDataW-1:0] rand_plane(bit bias_inside);
        logic [NormW-1:0] nx, ny, nz;
        logic [OffW-1:0]  off;
        nx = NormW'($urandom);
        ny = NormW'($urandom);
        nz = NormW'($urandom);
        if (bias_inside && $urandom_range(3) != 0)
            off = OffW'($urandom_range(32'h07FF_FFFF, 32'h0200_0000));
        else
            off = OffW'($urandom);
        return pack_plane(nx, ny, nz, off);
    endfunction

    function automatic item_t make_item(logic [FuncW-1:0] func, int px, int py, int pz,
                                        int sx, int sy, int sz);
        item_t it;
        it         = '0;
        it.func    = func;
        it.pos_x   = CoordW'(px);
        it.pos_y   = CoordW'(py);
        it.pos_z   = CoordW'(pz);
        it.size_x  = SizeW'(sx);
        it.size_y  = CoordW'(sy);
        it.size_z  = SizeW'(sz);
        return it;
    endfunction

    function automatic logic [CoordW-1:0] rand_coord();
        if ($urandom_range(1) == 0) return CoordW'($urandom);
        return CoordW'(int'($urandom_range(6000)) - 3000);
    endfunction

    function automatic item_t rand_item();
        item_t it;
        int    pick;
        it   = '0;
        pick = $urandom_range(99);
        if (pick < 30)      it.func = FuncPoint;
        else if (pick < 65) it.func = FuncBox;
        else if (pick < 95) it.func = FuncColumn;
        else                it.func = FuncSpare;
        it.pos_x  = rand_coord();
        it.pos_y  = rand_coord();
        it.pos_z  = rand_coord();
        it.size_x = SizeW'($urandom);
        it.size_y = (it.func == FuncColumn) ? rand_coord() : CoordW'($urandom);
        it.size_z = SizeW'($urandom);
        return it;
    endfunction

    task automatic send_item(item_t it);
        if (!no_gaps && $urandom_range(99) < 7) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {it.size_z, it.size_y, it.size_x, it.pos_z, it.pos_y, it.pos_x};
        s_tuser  <= it.func;
        do @(posedge aclk); while (!s_tready);
        sb.note_item(it);
        items_sent++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (QuietCycles) @(posedge aclk);
    endtask

    task automatic load_planes();
        int idx;
        for (idx = 0; idx < PlaneCount; idx++) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= CfgIdxW'(idx);
            cfg_wdata <= plane_set[idx];
            @(posedge aclk);
            sb.set_plane(idx, plane_set[idx]);
        end
        // indexes past the last plane must be dropped
        idx = FirstFreeIdx + $urandom_range(1);
        cfg_index <= CfgIdxW'(idx);
        cfg_wdata <= {$urandom, $urandom};
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        settings_used++;
    endtask

    task automatic send_random(int count);
        repeat (count) send_item(rand_item());
    endtask

    initial begin
        m_tready = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HoldCycles) @(posedge aclk);
            end else begin
                m_tready <= no_gaps || ($urandom_range(99) >= 7);
            end
            @(posedge aclk);
            if (m_tvalid && m_tready) sb.check_result(m_tdata);
        end
    end

    initial begin
        int i;
        sb            = new();
        aresetn       = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_index     = '0;
        cfg_wdata     = '0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = '0;
        no_gaps       = 1'b0;
        hold_req      = 1'b0;
        cycle_count   = 0;
        settings_used = 0;
        items_sent    = 0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // zero planes after reset never cull
        send_item(make_item(FuncPoint, -32768, -32768, -32768, 4095, 32767, 4095));
        send_item(make_item(FuncBox, 32767, 32767, 32767, 4095, 32767, 4095));
        send_item(make_item(FuncColumn, -32768, 32767, -32768, 0, -32768, 0));
        send_item(make_item(FuncSpare, 12, -7, 0, 1, 1, 1));
        send_random(40);
        drain();

        // x >= 0, y >= 100, z <= 1000, zero distance on each face
        plane_set[0] = pack_plane(12'sd1024, '0, '0, '0);
        plane_set[1] = pack_plane('0, 12'sd1024, '0, OffW'(-100 * 1024));
        plane_set[2] = pack_plane('0, '0, -12'sd1024, OffW'(1000 * 1024));
        for (i = 3; i < PlaneCount; i++) plane_set[i] = '0;
        load_planes();
        send_item(make_item(FuncPoint, 0, 100, 1000, 0, 0, 0));
        send_item(make_item(FuncPoint, -1, 100, 1000, 0, 0, 0));
        send_item(make_item(FuncPoint, 0, 99, 1000, 0, 0, 0));
        send_item(make_item(FuncPoint, 0, 100, 1001, 0, 0, 0));
        send_item(make_item(FuncBox, -5, 100, 1000, 5, 0, 4095));
        send_item(make_item(FuncBox, -6, 100, 1000, 5, 0, 0));
        send_item(make_item(FuncBox, 0, 90, 1000, 0, 10, 0));
        send_item(make_item(FuncBox, 0, -32768, 1000, 0, 100, 0));
        send_item(make_item(FuncColumn, 0, -32768, 1000, 0, 100, 0));
        send_item(make_item(FuncColumn, 0, 32767, 1000, 0, 99, 0));
        send_item(make_item(FuncColumn, 0, 32767, 1000, 0, -32768, 4095));
        send_item(make_item(FuncSpare, 0, -32768, 1000, 4095, 32767, 0));
        send_item(make_item(FuncSpare, 5, 100, -32768, 4095, -32768, 4095));
        send_item(make_item(FuncBox, -4095, 100, 1000, 4095, 0, 0));
        send_item(make_item(FuncPoint, 32767, 32767, -32768, 0, 0, 0));
        send_item(make_item(FuncPoint, -32768, 32767, -32768, 0, 0, 0));
        send_random(60);
        drain();

        for (i = 0; i < PlaneCount; i++) plane_set[i] = rand_plane(1'b1);
        load_planes();
        send_random(PhaseItems);
        drain();

        no_gaps = 1'b1;
        for (i = 0; i < PlaneCount; i++) plane_set[i] = rand_plane(1'b1);
        load_planes();
        send_random(PhaseItems);
        drain();
        no_gaps = 1'b0;

        for (i = 0; i < PlaneCount; i++) plane_set[i] = rand_plane(1'b1);
        load_planes();
        send_random(50);
        hold_req = 1'b1;
        send_random(PhaseItems - 50);
        drain();

        // extreme normals and offsets
        plane_set[0] = pack_plane(12'h7FF, 12'h7FF, 12'h7FF, 28'h7FF_FFFF);
        plane_set[1] = pack_plane(12'h800, 12'h800, 12'h800, 28'h7FF_FFFF);
        plane_set[2] = pack_plane(12'hFFF, 12'hFFF, 12'hFFF, 28'h7FF_FFFF);
        plane_set[3] = pack_plane(12'h001, 12'h001, 12'h001, 28'h800_0000);
        plane_set[4] = '0;
        plane_set[5] = {CfgDataW{1'b1}};
        load_planes();
        send_random(150);
        drain();

        for (i = 0; i < PlaneCount; i++) plane_set[i] = rand_plane(1'b0);
        load_planes();
        send_random(150);
        drain();

        for (i = 0; i < PlaneCount; i++) plane_set[i] = rand_plane(1'b1);
        plane_set[$urandom_range(PlaneCount - 1)] = '0;
        load_planes();
        send_random(PhaseItems / 2);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        send_random(PhaseItems / 2);
        drain();

        for (i = 0; i < PlaneCount; i++) plane_set[i] = rand_plane(1'b1);
        load_planes();
        send_random(PhaseItems);
        drain();

        while (sb.pending() != 0) @(posedge aclk);
        repeat (DrainCycles) @(posedge aclk);
        $display("Covered %0d items over %0d plane settings: %0d visible, %0d culled",
                 items_sent, settings_used, sb.seen_visible, sb.checked - sb.seen_visible);
        $display("Point, box, column and unused-kind tests, with stalls on both sides");
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
